>>> hw/rtl/pdft_pkg.sv
// Shared types and constants for the pulse-distance frame transmitter.
package pdft_pkg;

    localparam int TICK_W         = 16;
    localparam int CMD_BITS       = 12;
    localparam int CMD_IDX_W      = $clog2(CMD_BITS);
    localparam int CFG_IDX_W      = 3;
    localparam int DATA_BITS_DEF  = 12;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Reset lengths, in ticks
    localparam logic [TICK_W-1:0] HDR_MARK_RST    = 16'd3000;
    localparam logic [TICK_W-1:0] HDR_SPACE_RST   = 16'd1000;
    localparam logic [TICK_W-1:0] MARK_RST        = 16'd1000;
    localparam logic [TICK_W-1:0] ZERO_SPACE_RST  = 16'd1000;
    localparam logic [TICK_W-1:0] ONE_SPACE_RST   = 16'd2000;
    localparam logic [TICK_W-1:0] FTR_SPACE_RST   = 16'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HDR_MARK   = 3'd0,
        REG_HDR_SPACE  = 3'd1,
        REG_MARK       = 3'd2,
        REG_ZERO_SPACE = 3'd3,
        REG_ONE_SPACE  = 3'd4,
        REG_FTR_SPACE  = 3'd5
    } pdft_reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] hdr_mark;
        logic [TICK_W-1:0] hdr_space;
        logic [TICK_W-1:0] mark;
        logic [TICK_W-1:0] zero_space;
        logic [TICK_W-1:0] one_space;
        logic [TICK_W-1:0] ftr_space;
    } pdft_cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic frame_done;
    } pdft_result_t;

endpackage

>>> hw/rtl/pdft_cfg_regs.sv
// Segment length register file for the pulse-distance frame transmitter.
module pdft_cfg_regs
    import pdft_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [TICK_W-1:0]    wr_data,
    output pdft_cfg_t            cfg
);

    pdft_cfg_t cfg_reg;
    pdft_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (pdft_reg_idx_t'(wr_index))
                REG_HDR_MARK:   cfg_next.hdr_mark   = wr_data;
                REG_HDR_SPACE:  cfg_next.hdr_space  = wr_data;
                REG_MARK:       cfg_next.mark       = wr_data;
                REG_ZERO_SPACE: cfg_next.zero_space = wr_data;
                REG_ONE_SPACE:  cfg_next.one_space  = wr_data;
                REG_FTR_SPACE:  cfg_next.ftr_space  = wr_data;
                default:        cfg_next = cfg_reg; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hdr_mark   <= HDR_MARK_RST;
            cfg_reg.hdr_space  <= HDR_SPACE_RST;
            cfg_reg.mark       <= MARK_RST;
            cfg_reg.zero_space <= ZERO_SPACE_RST;
            cfg_reg.one_space  <= ONE_SPACE_RST;
            cfg_reg.ftr_space  <= FTR_SPACE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/pdft_seq.sv
// Frame sequencer: segment timing, phase and line level, one item per cycle.
module pdft_seq
    import pdft_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_en,
    input  logic                item_cmd,
    input  logic [CMD_BITS-1:0] item_command,
    input  pdft_cfg_t           cfg,
    output pdft_result_t        result
);

    localparam int PHASE_W = $clog2(DATA_BITS + 2);
    localparam int POS_W   = (PHASE_W > CMD_IDX_W) ? PHASE_W : CMD_IDX_W;
    localparam logic [PHASE_W-1:0] LAST_DATA = PHASE_W'(DATA_BITS);
    localparam logic [POS_W-1:0]   CMD_LIM   = POS_W'(CMD_BITS);

    logic                active_reg, active_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                level_reg, level_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic [CMD_BITS-1:0] cmd_reg, cmd_next;

    logic [TICK_W-1:0]   elapsed_inc;
    logic [TICK_W-1:0]   seg_len;
    logic [POS_W-1:0]    bit_pos;
    logic                bit_one;
    logic                done;

    // Bit position of the current data phase, MSB first; positions past
    // the command width read as zero.
    assign bit_pos = POS_W'(LAST_DATA) - POS_W'(phase_reg);
    assign bit_one = (bit_pos < CMD_LIM) && cmd_reg[bit_pos[CMD_IDX_W-1:0]];

    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg
                                                   : elapsed_reg + 1'b1;

    always_comb begin
        if (phase_reg == '0) begin
            seg_len = level_reg ? cfg.hdr_mark : cfg.hdr_space;
        end else if (level_reg) begin
            seg_len = cfg.mark;
        end else if (phase_reg <= LAST_DATA) begin
            seg_len = bit_one ? cfg.one_space : cfg.zero_space;
        end else begin
            seg_len = cfg.ftr_space;
        end
    end

    always_comb begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        level_next   = level_reg;
        elapsed_next = elapsed_reg;
        cmd_next     = cmd_reg;
        done         = 1'b0;
        if (item_en) begin
            if (item_cmd) begin
                // start is honored only while idle
                if (!active_reg) begin
                    active_next  = 1'b1;
                    cmd_next     = item_command;
                    phase_next   = '0;
                    level_next   = 1'b1;
                    elapsed_next = '0;
                end
            end else if (active_reg) begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= seg_len) begin
                    elapsed_next = '0;
                    if (level_reg) begin
                        level_next = 1'b0;
                    end else if (phase_reg <= LAST_DATA) begin
                        level_next = 1'b1;
                        phase_next = phase_reg + PHASE_W'(1);
                    end else begin
                        active_next = 1'b0;
                        phase_next  = '0;
                        done        = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            phase_reg   <= '0;
            level_reg   <= 1'b0;
            elapsed_reg <= '0;
        end else begin
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

    assign result.line_level = level_next;
    assign result.busy       = active_next;
    assign result.frame_done = done;

endmodule

>>> hw/rtl/pulse_distance_frame_transmitter.sv
// Top level of the pulse-distance frame transmitter.
//
// Usage:
//   Input channel (s_valid/s_ready, s_cmd, s_command): each transfer is one
//   item. s_cmd = 1 starts a frame carrying s_command (ignored while a frame
//   is in flight); s_cmd = 0 is one time tick. The frame is a header
//   (mark, space), DATA_BITS data bits MSB first (mark, short or long
//   space), and a footer (mark, long space).
//   Result channel (m_valid/m_ready): exactly one result transfer per input
//   transfer, in order: line level, busy flag and frame_done after the item.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes one of
//   the six 16-bit segment lengths; always ready, unknown indexes dropped.
//   Write only while no item is in flight.
// Timing:
//   The input transfer is registered, then goes through sequencer logic into
//   the output register, which drives the result channel. One item per cycle
//   sustained while m_ready stays high; the only loop is the sequencer state
//   update.
// Stall/reset:
//   When m_ready is low the result holds; the input register still takes one
//   more item, then s_ready drops. Synchronous reset clears both stages,
//   idles the sequencer with the line low and restores default lengths.
module pulse_distance_frame_transmitter
    import pdft_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // item input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [CMD_BITS-1:0]  s_command,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_line_level,
    output logic                 m_busy_res,
    output logic                 m_frame_done,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    logic                in_valid_reg, in_valid_next;
    logic                in_cmd_reg;
    logic [CMD_BITS-1:0] in_command_reg;
    logic                out_valid_reg, out_valid_next;
    pdft_result_t        out_reg;
    pdft_result_t        seq_result;
    pdft_cfg_t           cfg;
    logic                out_free;
    logic                in_xfer;
    logic                seq_fire;

    // Output slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_ready;
    assign seq_fire = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_xfer  = s_valid && s_ready;

    assign cfg_ready = 1'b1;

    pdft_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pdft_seq #(
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_en      (seq_fire),
        .item_cmd     (in_cmd_reg),
        .item_command (in_command_reg),
        .cfg          (cfg),
        .result       (seq_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (seq_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (seq_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_cmd_reg     <= s_cmd;
            in_command_reg <= s_command;
        end
        if (seq_fire) begin
            out_reg <= seq_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_line_level = out_reg.line_level;
    assign m_busy_res   = out_reg.busy;
    assign m_frame_done = out_reg.frame_done;

endmodule

>>> hw/rtl/pdft_checker.sv
// Port-level checker for the pulse-distance frame transmitter, with bind.
module pdft_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_line_level,
    input logic m_busy_res,
    input logic m_frame_done
);

    // result channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // frame end leaves the block idle with the line low
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> !m_busy_res && !m_line_level)
        else $error("frame_done while busy or line high");

    // the line is only driven high during a frame
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_line_level)
        else $error("line high while idle");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_level)
            && $stable(m_busy_res) && $stable(m_frame_done))
        else $error("result changed under stall");

endmodule

bind pulse_distance_frame_transmitter pdft_checker u_pdft_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_line_level (m_line_level),
    .m_busy_res   (m_busy_res),
    .m_frame_done (m_frame_done)
);

>>> tb/tb_pulse_distance_frame_transmitter.sv
// Self-checking testbench for the pulse-distance frame transmitter.
module tb_pulse_distance_frame_transmitter;
    import pdft_pkg::*;

    localparam int FRAME_BITS  = DATA_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 4;  // two-stage pipe plus margin

    // item opcodes on s_cmd
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_cmd     = 1'b0;
    logic [CMD_BITS-1:0]  s_command = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b1;
    logic                 m_line_level;
    logic                 m_busy_res;
    logic                 m_frame_done;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_data  = '0;

    pulse_distance_frame_transmitter DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_command    (s_command),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_level (m_line_level),
        .m_busy_res   (m_busy_res),
        .m_frame_done (m_frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Frame predictor: mirrors the sequencer state, one step per accepted
    // input transfer.
    // ------------------------------------------------------------------
    pdft_cfg_t           seg_len;
    logic                fr_active;
    int unsigned         fr_phase;     // 0 header, 1..FRAME_BITS data, then footer
    logic                fr_level;
    logic [TICK_W-1:0]   fr_elapsed;
    logic [CMD_BITS-1:0] fr_command;

    pdft_result_t line_expect_q[$];
    int           mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    bit           idle_on        = 1'b1;

    function automatic logic [TICK_W-1:0] segment_len();
        int pos;
        if (fr_phase == 0)
            return fr_level ? seg_len.hdr_mark : seg_len.hdr_space;
        if (fr_level)
            return seg_len.mark;
        if (fr_phase <= FRAME_BITS) begin
            pos = FRAME_BITS - int'(fr_phase);
            // bits above the command width read as zero
            if (pos >= CMD_BITS || !fr_command[pos])
                return seg_len.zero_space;
            return seg_len.one_space;
        end
        return seg_len.ftr_space;
    endfunction

    function automatic pdft_result_t advance_frame(input logic cmd,
                                                   input logic [CMD_BITS-1:0] command);
        pdft_result_t r;
        r.frame_done = 1'b0;
        if (cmd == OP_START) begin
            // a start while a frame is in flight is dropped outright
            if (!fr_active) begin
                fr_active  = 1'b1;
                fr_command = command;
                fr_phase   = 0;
                fr_level   = 1'b1;
                fr_elapsed = '0;
            end
        end else if (fr_active) begin
            if (fr_elapsed != TICK_MAX)
                fr_elapsed = fr_elapsed + 1'b1;
            if (fr_elapsed >= segment_len()) begin
                fr_elapsed = '0;
                if (fr_level) begin
                    fr_level = 1'b0;
                end else if (fr_phase <= FRAME_BITS) begin
                    fr_level = 1'b1;
                    fr_phase++;
                end else begin
                    fr_active    = 1'b0;
                    fr_phase     = 0;
                    r.frame_done = 1'b1;
                end
            end
        end
        r.line_level = fr_level;
        r.busy       = fr_active;
        return r;
    endfunction

    initial begin
        seg_len.hdr_mark   = HDR_MARK_RST;
        seg_len.hdr_space  = HDR_SPACE_RST;
        seg_len.mark       = MARK_RST;
        seg_len.zero_space = ZERO_SPACE_RST;
        seg_len.one_space  = ONE_SPACE_RST;
        seg_len.ftr_space  = FTR_SPACE_RST;
        fr_active  = 1'b0;
        fr_phase   = 0;
        fr_level   = 1'b0;
        fr_elapsed = '0;
        fr_command = '0;
    end

    // ------------------------------------------------------------------
    // Channel drivers. All tasks start and end just after a rising edge.
    // ------------------------------------------------------------------

    // One input transfer; the expectation is queued at the accepting edge.
    task automatic send_item(input logic cmd, input logic [CMD_BITS-1:0] command);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_command <= command;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        line_expect_q.push_back(advance_frame(cmd, command));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_HDR_MARK:   seg_len.hdr_mark   = data;
            REG_HDR_SPACE:  seg_len.hdr_space  = data;
            REG_MARK:       seg_len.mark       = data;
            REG_ZERO_SPACE: seg_len.zero_space = data;
            REG_ONE_SPACE:  seg_len.one_space  = data;
            REG_FTR_SPACE:  seg_len.ftr_space  = data;
            default: ;  // unmapped index, write dropped
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_lengths(input pdft_cfg_t lens);
        write_reg(REG_HDR_MARK,   lens.hdr_mark);
        write_reg(REG_HDR_SPACE,  lens.hdr_space);
        write_reg(REG_MARK,       lens.mark);
        write_reg(REG_ZERO_SPACE, lens.zero_space);
        write_reg(REG_ONE_SPACE,  lens.one_space);
        write_reg(REG_FTR_SPACE,  lens.ftr_space);
    endtask

    // Sender holds off until every result is back; the block is then quiet
    // and a register write is safe even in the middle of a frame.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Tick until the predictor says the frame is over.
    task automatic finish_frame();
        while (fr_active) send_item(OP_TICK, CMD_BITS'($urandom_range(0, 4095)));
    endtask

    function automatic logic [TICK_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 11)
            return TICK_MAX;
        return TICK_W'($urandom_range(1, 6));
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the in-order checker.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && aresetn && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        pdft_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result transfer with no item outstanding", $time);
            end else begin
                want = line_expect_q.pop_front();
                if (want.line_level !== m_line_level) begin
                    mismatch_count++;
                    $display("%0t: line_level expected %0b actual %0b",
                             $time, want.line_level, m_line_level);
                end
                if (want.busy !== m_busy_res) begin
                    mismatch_count++;
                    $display("%0t: busy_res expected %0b actual %0b",
                             $time, want.busy, m_busy_res);
                end
                if (want.frame_done !== m_frame_done) begin
                    mismatch_count++;
                    $display("%0t: frame_done expected %0b actual %0b",
                             $time, want.frame_done, m_frame_done);
                end
            end
        end
    end

    // Watchdog: the slowest legal run is far below this.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks while idle do nothing; a start under default lengths raises the
    // line; a second start during the frame is dropped and is not a tick.
    task automatic test_idle_and_busy_start();
        send_item(OP_TICK,  12'hFFF);
        send_item(OP_TICK,  12'h000);
        send_item(OP_START, 12'hA5A);
        send_item(OP_START, 12'h5A5);
        repeat (3) send_item(OP_TICK, 12'h000);
        wait_results_drained();
    endtask

    // Header mark shrinks below the count already reached: the segment must
    // end on the very next tick. Then run the frame out with short lengths.
    task automatic test_mid_segment_shrink();
        pdft_cfg_t lens;
        lens.hdr_mark   = 16'd2;
        lens.hdr_space  = 16'd1;
        lens.mark       = 16'd1;
        lens.zero_space = 16'd1;
        lens.one_space  = 16'd2;
        lens.ftr_space  = 16'd3;
        set_lengths(lens);
        finish_frame();
        wait_results_drained();
    endtask

    // Zero lengths end each segment after one tick; spare indexes ignored.
    task automatic test_zero_lengths();
        set_lengths('0);
        write_reg(REG_SPARE_6, TICK_MAX);
        write_reg(REG_SPARE_7, 16'h0001);
        send_item(OP_START, 12'h800);
        finish_frame();
        send_item(OP_TICK, 12'h7FF);
        wait_results_drained();
    endtask

    // Longest header mark, ticked back to back so the line stays high, then
    // the mark is cut short so it ends on the next tick.
    task automatic test_max_length();
        pdft_cfg_t lens;
        lens.hdr_mark   = TICK_MAX;
        lens.hdr_space  = 16'd1;
        lens.mark       = 16'd1;
        lens.zero_space = 16'd1;
        lens.one_space  = 16'd1;
        lens.ftr_space  = 16'd1;
        idle_on = 1'b0;
        set_lengths(lens);
        send_item(OP_START, 12'hFFF);
        repeat (40) send_item(OP_TICK, 12'h000);
        wait_results_drained();
        write_reg(REG_HDR_MARK, 16'd1);
        finish_frame();
        wait_results_drained();
        idle_on = 1'b1;
    endtask

    // Phases of random lengths; inside a phase mostly well-formed frames
    // (start when idle, ticks when busy), with stray starts and idle ticks.
    // Register writes between phases often land mid-frame.
    task automatic test_random_traffic();
        int i;
        for (int ph = 0; ph < 6; ph++) begin
            for (i = 0; i < 8; i++)
                if ($urandom_range(0, 1))
                    write_reg(CFG_IDX_W'(i), pick_len());
            for (i = 0; i < 260; i++) begin
                if (!fr_active)
                    send_item(($urandom_range(0, 4) != 0) ? OP_START : OP_TICK,
                              CMD_BITS'($urandom_range(0, 4095)));
                else
                    send_item(($urandom_range(0, 19) == 0) ? OP_START : OP_TICK,
                              CMD_BITS'($urandom_range(0, 4095)));
            end
            wait_results_drained();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back_tail();
        pdft_cfg_t lens;
        lens.hdr_mark   = 16'd3;
        lens.hdr_space  = 16'd2;
        lens.mark       = 16'd1;
        lens.zero_space = 16'd1;
        lens.one_space  = 16'd3;
        lens.ftr_space  = 16'd4;
        idle_on = 1'b0;
        set_lengths(lens);
        repeat (3) begin
            send_item(OP_START, CMD_BITS'($urandom_range(0, 4095)));
            finish_frame();
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_and_busy_start();
        test_mid_segment_shrink();
        test_zero_lengths();
        test_max_length();
        test_random_traffic();
        test_back_to_back_tail();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && line_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pdft_pkg.sv
hw/rtl/pdft_cfg_regs.sv
hw/rtl/pdft_seq.sv
hw/rtl/pulse_distance_frame_transmitter.sv
hw/rtl/pdft_checker.sv
tb/tb_pulse_distance_frame_transmitter.sv
